>>> sv/aml_s5_pkg.sv
// Package of types, codes and helpers for the _S5_ sleep type extractor.
`timescale 1ns / 1ps

package aml_s5_pkg;

	// Parser phase while walking the table body
	typedef enum logic [3:0] {
		PH_SEARCH   = 4'd0,
		PH_PKG_OP   = 4'd1,
		PH_PKG_LEAD = 4'd2,
		PH_PKG_SKIP = 4'd3,
		PH_COUNT    = 4'd4,
		PH_A_OP     = 4'd5,
		PH_A_FIRST  = 4'd6,
		PH_A_REST   = 4'd7,
		PH_B_OP     = 4'd8,
		PH_B_FIRST  = 4'd9,
		PH_B_REST   = 4'd10,
		PH_DONE     = 4'd11
	} phase_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_NO_PKG    = 3'd2,
		ST_FEW       = 3'd3,
		ST_BAD_INT   = 3'd4,
		ST_TRUNC     = 3'd5
	} status_t;

	// AML opcodes and integer prefixes
	localparam logic [7:0] PACKAGE_OP    = 8'h12;
	localparam logic [7:0] ZERO_OP       = 8'h00;
	localparam logic [7:0] ONE_OP        = 8'h01;
	localparam logic [7:0] ONES_OP       = 8'hFF;
	localparam logic [7:0] BYTE_PREFIX   = 8'h0A;
	localparam logic [7:0] WORD_PREFIX   = 8'h0B;
	localparam logic [7:0] DWORD_PREFIX  = 8'h0C;
	localparam logic [7:0] QWORD_PREFIX  = 8'h0E;
	localparam logic [7:0] PKG_LEN_MASK  = 8'hC0;
	localparam logic [7:0] CHAR_UNDER    = 8'h5F;
	localparam logic [23:0] NAME_HEAD    = 24'h5F_53_35; // "_S5"

	localparam int SLP_TYP_SHIFT = 10;
	localparam logic [15:0] SLP_EN = 16'h2000;

	// Build a PM1 control word from a 6-bit sleep type
	function automatic logic [15:0] pm1_word(input logic [5:0] v);
		logic [15:0] w;
		w = {v, 10'b0};
		return w | SLP_EN;
	endfunction

endpackage

>>> sv/aml_s5_sleep_type_extract.sv
// Top level of the _S5_ sleep type extractor for a definition table byte stream.
`timescale 1ns / 1ps

// Takes the body of a DSDT one byte per request, end_of_table marking the last
// byte, and returns one result per table: a status and the two PM1 control words
// (sleep type << 10 with the sleep enable bit) for the first _S5_ package found.
// Throughput is one byte per cycle: each byte is registered, parsed by a shallow
// per-byte state machine and any result lands in a single output register. The
// input stalls only while that output register holds a result that is not taken.
// After a result the remaining bytes of the table are consumed and dropped; the
// parser returns to its reset state after every last byte.
module aml_s5_sleep_type_extract
	import aml_s5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_table,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] pm1_word_a,
	output logic [15:0] pm1_word_b
);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state
	phase_t      phase_q;
	logic [23:0] window_q;
	logic [3:0]  skip_q;
	logic [5:0]  val_a_q;
	logic [5:0]  val_b_q;

	// Output register
	logic        out_valid_q;
	status_t     status_q;
	logic [15:0] word_a_q;
	logic [15:0] word_b_q;

	// Next-state logic
	phase_t      phase_d;
	logic [23:0] window_d;
	logic [3:0]  skip_d;
	logic [5:0]  val_a_d;
	logic [5:0]  val_b_d;
	logic        res_hit;
	status_t     res_status;
	logic        advance;
	logic        step;
	logic        prefix_ok;
	logic        prefix_const;
	logic [5:0]  prefix_val;
	logic [3:0]  prefix_len;
	logic [3:0]  skip_dec;

	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Decode an AML integer prefix
	always_comb begin
		prefix_ok    = 1'b1;
		prefix_const = 1'b0;
		prefix_val   = 6'd0;
		prefix_len   = 4'd0;
		unique case (byte_s1)
			ZERO_OP: begin
				prefix_const = 1'b1;
			end
			ONE_OP: begin
				prefix_const = 1'b1;
				prefix_val   = 6'd1;
			end
			ONES_OP: begin
				prefix_const = 1'b1;
				prefix_val   = 6'h3F;
			end
			BYTE_PREFIX:  prefix_len = 4'd1;
			WORD_PREFIX:  prefix_len = 4'd2;
			DWORD_PREFIX: prefix_len = 4'd4;
			QWORD_PREFIX: prefix_len = 4'd8;
			default:      prefix_ok  = 1'b0;
		endcase
	end

	assign skip_dec = skip_q - 4'd1;

	// Advance the parser by one byte
	always_comb begin
		phase_d    = phase_q;
		window_d   = window_q;
		skip_d     = skip_q;
		val_a_d    = val_a_q;
		val_b_d    = val_b_q;
		res_hit    = 1'b0;
		res_status = ST_OK;
		unique case (phase_q)
			PH_SEARCH: begin
				if (byte_s1 == CHAR_UNDER && window_q == NAME_HEAD)
					phase_d = PH_PKG_OP;
				window_d = {window_q[15:0], byte_s1};
			end
			PH_PKG_OP: begin
				if (byte_s1 == PACKAGE_OP) begin
					phase_d = PH_PKG_LEAD;
				end else begin
					res_hit    = 1'b1;
					res_status = ST_NO_PKG;
				end
			end
			PH_PKG_LEAD: begin
				skip_d  = {2'b00, byte_s1[7:6]};
				phase_d = ((byte_s1 & PKG_LEN_MASK) != 8'h00) ? PH_PKG_SKIP : PH_COUNT;
			end
			PH_PKG_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 4'd0)
					phase_d = PH_COUNT;
			end
			PH_COUNT: begin
				if (byte_s1 < 8'd2) begin
					res_hit    = 1'b1;
					res_status = ST_FEW;
				end else begin
					phase_d = PH_A_OP;
				end
			end
			PH_A_OP, PH_B_OP: begin
				if (!prefix_ok) begin
					res_hit    = 1'b1;
					res_status = ST_BAD_INT;
				end else if (prefix_const) begin
					if (phase_q == PH_A_OP) begin
						val_a_d = prefix_val;
						phase_d = PH_B_OP;
					end else begin
						val_b_d = prefix_val;
						res_hit = 1'b1;
					end
				end else begin
					skip_d  = prefix_len;
					phase_d = (phase_q == PH_A_OP) ? PH_A_FIRST : PH_B_FIRST;
				end
			end
			PH_A_FIRST, PH_A_REST: begin
				if (phase_q == PH_A_FIRST)
					val_a_d = byte_s1[5:0];
				skip_d  = skip_dec;
				phase_d = (skip_dec == 4'd0) ? PH_B_OP : PH_A_REST;
			end
			PH_B_FIRST, PH_B_REST: begin
				if (phase_q == PH_B_FIRST)
					val_b_d = byte_s1[5:0];
				skip_d  = skip_dec;
				phase_d = PH_B_REST;
				if (skip_dec == 4'd0)
					res_hit = 1'b1;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		if (res_hit)
			phase_d = PH_DONE;
		// Close the table on its last byte
		if (last_s1) begin
			if (!res_hit && phase_q != PH_DONE) begin
				res_hit    = 1'b1;
				res_status = (phase_d == PH_SEARCH) ? ST_NOT_FOUND : ST_TRUNC;
			end
			phase_d  = PH_SEARCH;
			window_d = 24'd0;
			skip_d   = 4'd0;
		end
	end

	// Input register: load a request whenever the stage is free or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_table;
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			window_q <= 24'd0;
			skip_q   <= 4'd0;
			val_a_q  <= 6'd0;
			val_b_q  <= 6'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			skip_q   <= skip_d;
			val_a_q  <= last_s1 ? 6'd0 : val_a_d;
			val_b_q  <= last_s1 ? 6'd0 : val_b_d;
		end
	end

	// Output register: hold until taken, load a new result when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_hit) begin
			status_q <= res_status;
			word_a_q <= (res_status == ST_OK) ? pm1_word(val_a_d) : 16'd0;
			word_b_q <= (res_status == ST_OK) ? pm1_word(val_b_d) : 16'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign pm1_word_a = word_a_q;
	assign pm1_word_b = word_b_q;

	// The parser is back at the name search after every last byte
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> (phase_q == PH_SEARCH))
		else $error("parser not reset after last byte");

	// A stalled result blocks the parser
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> $stable(phase_q))
		else $error("parser advanced while result stalled");

	// Failed results carry zero control words
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (word_a_q == 16'd0 && word_b_q == 16'd0))
		else $error("error result with non-zero control words");

	// A finished table stays silent up to and including its last byte
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_DONE) |-> !res_hit)
		else $error("second result for one table");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the _S5_ sleep type extractor.
`timescale 1ns / 1ps

module tb;
	import aml_s5_pkg::*;

	localparam int RANDOM_BYTES = 550;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN        = 20;
	localparam int PRINT_LIMIT  = 30;
	localparam logic [7:0] CH_S = NAME_HEAD[15:8];
	localparam logic [7:0] CH_5 = NAME_HEAD[7:0];

	typedef struct packed {
		status_t     st;
		logic [15:0] wa;
		logic [15:0] wb;
	} result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eot;
		logic       typed;
		result_t    want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_table = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [15:0] pm1_word_a;
	logic [15:0] pm1_word_b;

	// Parser shadow state
	phase_t      ph;
	logic [23:0] win;
	logic [3:0]  skip_cnt;
	logic [5:0]  slp_a;
	logic [5:0]  slp_b;
	bit          done_flag;

	result_t     sleep_words_q[$];
	stim_row_t   dir_rows[$];
	logic [7:0]  tbl_q[$];

	// Side band travelling with the request on the input channel
	bit          tag_typed = 1'b0;
	result_t     tag_want;

	bit          steady_in = 1'b0;
	bit          hold_req = 1'b0;
	int          errors = 0;
	int          bytes_sent = 0;
	int          tables_sent = 0;
	int          results_seen = 0;
	int          status_seen[8];

	aml_s5_sleep_type_extract dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_table (end_of_table),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.pm1_word_a   (pm1_word_a),
		.pm1_word_b   (pm1_word_b)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("aml_s5_sleep_type_extract verification failed");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (errors < PRINT_LIMIT)
			$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	// Number of data bytes after an integer prefix, -1 for an unknown prefix
	function automatic int int_len(input logic [7:0] p);
		case (p)
			ZERO_OP, ONE_OP, ONES_OP: return 0;
			BYTE_PREFIX: return 1;
			WORD_PREFIX: return 2;
			DWORD_PREFIX: return 4;
			QWORD_PREFIX: return 8;
			default: return -1;
		endcase
	endfunction

	function automatic logic [15:0] ctl_word(input logic [5:0] v);
		logic [15:0] w;
		w = {10'd0, v};
		w = w << SLP_TYP_SHIFT;
		return w | SLP_EN;
	endfunction

	task automatic clear_parser();
		ph = PH_SEARCH;
		win = 24'd0;
		skip_cnt = 4'd0;
		slp_a = 6'd0;
		slp_b = 6'd0;
		done_flag = 1'b0;
	endtask

	// Advance the shadow parser by one byte; got is set when a result is due
	task automatic parse_byte(input logic [7:0] b, input logic last, output bit got,
			output result_t r);
		bit fire;
		bit on_b;
		int k;
		logic [5:0] imm;
		status_t code;
		fire = 1'b0;
		code = ST_OK;
		on_b = (ph == PH_B_OP) || (ph == PH_B_FIRST) || (ph == PH_B_REST);
		imm = (b == ONES_OP) ? 6'h3F : {5'd0, b[0]};
		case (ph)
			PH_SEARCH: begin
				if (b == CHAR_UNDER && win == NAME_HEAD)
					ph = PH_PKG_OP;
				win = {win[15:0], b};
			end
			PH_PKG_OP: begin
				if (b == PACKAGE_OP)
					ph = PH_PKG_LEAD;
				else begin
					fire = 1'b1;
					code = ST_NO_PKG;
				end
			end
			PH_PKG_LEAD: begin
				skip_cnt = {2'b00, b[7:6]};
				ph = (b[7:6] != 2'b00) ? PH_PKG_SKIP : PH_COUNT;
			end
			PH_PKG_SKIP: begin
				skip_cnt = skip_cnt - 4'd1;
				if (skip_cnt == 4'd0)
					ph = PH_COUNT;
			end
			PH_COUNT: begin
				if (b < 8'd2) begin
					fire = 1'b1;
					code = ST_FEW;
				end else
					ph = PH_A_OP;
			end
			PH_A_OP, PH_B_OP: begin
				k = int_len(b);
				if (k < 0) begin
					fire = 1'b1;
					code = ST_BAD_INT;
				end else if (k == 0) begin
					if (on_b) begin
						slp_b = imm;
						fire = 1'b1;
						code = ST_OK;
					end else begin
						slp_a = imm;
						ph = PH_B_OP;
					end
				end else begin
					skip_cnt = k[3:0];
					ph = on_b ? PH_B_FIRST : PH_A_FIRST;
				end
			end
			PH_A_FIRST, PH_B_FIRST, PH_A_REST, PH_B_REST: begin
				// keep only the low six bits of the first data byte
				if (ph == PH_A_FIRST) begin
					slp_a = b[5:0];
					ph = PH_A_REST;
				end else if (ph == PH_B_FIRST) begin
					slp_b = b[5:0];
					ph = PH_B_REST;
				end
				skip_cnt = skip_cnt - 4'd1;
				if (skip_cnt == 4'd0) begin
					if (on_b) begin
						fire = 1'b1;
						code = ST_OK;
					end else
						ph = PH_B_OP;
				end
			end
			default: ;
		endcase
		if (fire) begin
			ph = PH_DONE;
			done_flag = 1'b1;
		end
		// the last byte closes a table that has not yet given its result
		if (last && !fire && !done_flag) begin
			fire = 1'b1;
			code = (ph == PH_SEARCH) ? ST_NOT_FOUND : ST_TRUNC;
		end
		r.st = code;
		r.wa = (fire && code == ST_OK) ? ctl_word(slp_a) : 16'h0000;
		r.wb = (fire && code == ST_OK) ? ctl_word(slp_b) : 16'h0000;
		got = fire;
		if (last)
			clear_parser();
	endtask

	task automatic row(input logic [7:0] b, input logic eot);
		stim_row_t s;
		s = '0;
		s.b = b;
		s.eot = eot;
		dir_rows.push_back(s);
	endtask

	task automatic row_out(input logic [7:0] b, input logic eot, input status_t st,
			input logic [15:0] wa, input logic [15:0] wb);
		stim_row_t s;
		s.b = b;
		s.eot = eot;
		s.typed = 1'b1;
		s.want.st = st;
		s.want.wa = wa;
		s.want.wb = wb;
		dir_rows.push_back(s);
	endtask

	task automatic put_name();
		tbl_q.push_back(CHAR_UNDER);
		tbl_q.push_back(CH_S);
		tbl_q.push_back(CH_5);
		tbl_q.push_back(CHAR_UNDER);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Bytes that often form part of the name, to exercise the match window
	function automatic logic [7:0] lure_byte();
		logic [7:0] x;
		x = 8'($urandom);
		case ($urandom_range(0, 3))
			0: return CHAR_UNDER;
			1: return CH_S;
			2: return CH_5;
			default: return x;
		endcase
	endfunction

	task automatic push_int(input bit bad);
		logic [7:0] p;
		logic [7:0] x;
		int n;
		if (bad) begin
			do begin
				p = 8'($urandom);
			end while (int_len(p) >= 0);
			tbl_q.push_back(p);
		end else begin
			case ($urandom_range(0, 6))
				0: p = ZERO_OP;
				1: p = ONE_OP;
				2: p = ONES_OP;
				3: p = BYTE_PREFIX;
				4: p = WORD_PREFIX;
				5: p = DWORD_PREFIX;
				default: p = QWORD_PREFIX;
			endcase
			tbl_q.push_back(p);
			n = int_len(p);
			repeat (n) begin
				x = 8'($urandom);
				tbl_q.push_back(x);
			end
		end
	endtask

	// Build one table body: mostly well formed _S5_ packages, some broken or cut short
	task automatic build_table();
		int kind;
		int cut;
		logic [7:0] lead;
		logic [7:0] x;
		kind = $urandom_range(0, 99);
		tbl_q.delete();
		repeat ($urandom_range(0, 3)) tbl_q.push_back(lure_byte());
		if (kind < 8) begin
			repeat ($urandom_range(1, 6)) tbl_q.push_back(lure_byte());
		end else begin
			put_name();
			x = 8'($urandom);
			tbl_q.push_back(kind < 14 ? x : PACKAGE_OP);
			lead = 8'($urandom);
			tbl_q.push_back(lead);
			repeat (lead[7:6]) begin
				x = 8'($urandom);
				tbl_q.push_back(x);
			end
			x = 8'($urandom);
			if (kind < 20)
				x = {7'd0, x[0]};
			else if (x < 8'd2)
				x = x + 8'd2;
			tbl_q.push_back(x);
			push_int(kind >= 20 && kind < 26);
			push_int(kind >= 26 && kind < 32);
			repeat ($urandom_range(0, 3)) begin
				x = 8'($urandom);
				tbl_q.push_back(x);
			end
		end
		// cut some tables short
		if ($urandom_range(0, 9) == 0 && tbl_q.size() > 1) begin
			cut = $urandom_range(1, tbl_q.size() - 1);
			while (tbl_q.size() > cut)
				x = tbl_q.pop_back();
		end
	endtask

	// Offer one request and hold it until it is taken
	task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
			input result_t want);
		int gap;
		gap = steady_in ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		data_byte = b;
		end_of_table = eot;
		tag_typed = typed;
		tag_want = want;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (eot)
			tables_sent++;
	endtask

	// Predict on every accepted request; check every accepted result
	always @(posedge clk) begin : track_ports
		bit got;
		result_t pred;
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_byte(data_byte, end_of_table, got, pred);
				if (tag_typed)
					pred = tag_want;
				if (got || tag_typed)
					sleep_words_q.push_back(pred);
			end
			if (out_valid && out_ready) begin
				if (sleep_words_q.size() == 0)
					flag_mismatch("result with none pending, status", {13'd0, status},
						16'h0000);
				else begin
					want = sleep_words_q.pop_front();
					if (status !== want.st)
						flag_mismatch("status", {13'd0, status}, {13'd0, want.st});
					if (pm1_word_a !== want.wa)
						flag_mismatch("pm1_word_a", pm1_word_a, want.wa);
					if (pm1_word_b !== want.wb)
						flag_mismatch("pm1_word_b", pm1_word_b, want.wb);
				end
				results_seen++;
				status_seen[status]++;
			end
		end
	end

	// Result side: random back-pressure, steady stretches and one long hold-off
	initial begin : receiver
		int stretch;
		int held;
		int r;
		stretch = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				held = 0;
				while (held < LONG_HOLD) begin
					@(negedge clk);
					held++;
				end
				out_ready = 1'b1;
				hold_req = 1'b0;
				stretch = 0;
			end else if (stretch > 0)
				stretch--;
			else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					out_ready = 1'b1;
					stretch = $urandom_range(20, 60);
				end else if (r < 11) begin
					out_ready = 1'b0;
					stretch = $urandom_range(8, 30);
				end else
					out_ready = ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin : stimulus
		stim_row_t s;
		result_t none;
		logic [7:0] x;
		int t;
		none = '0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		clear_parser();

		// well formed package: Ones then One
		row(CHAR_UNDER, 1'b0);
		row(CH_S, 1'b0);
		row(CH_5, 1'b0);
		row(CHAR_UNDER, 1'b0);
		row(PACKAGE_OP, 1'b0);
		row(8'h00, 1'b0);
		row(8'h02, 1'b0);
		row(ONES_OP, 1'b0);
		row_out(ONE_OP, 1'b1, ST_OK, 16'hFC00, 16'h2400);
		// no name in a one byte table
		row_out(8'h00, 1'b1, ST_NOT_FOUND, 16'h0000, 16'h0000);
		// wrong opcode after the name, then a dropped tail byte
		row(CHAR_UNDER, 1'b0);
		row(CH_S, 1'b0);
		row(CH_5, 1'b0);
		row(CHAR_UNDER, 1'b0);
		row_out(8'h07, 1'b0, ST_NO_PKG, 16'h0000, 16'h0000);
		row(8'hFF, 1'b1);
		// element count of one
		row(CHAR_UNDER, 1'b0);
		row(CH_S, 1'b0);
		row(CH_5, 1'b0);
		row(CHAR_UNDER, 1'b0);
		row(PACKAGE_OP, 1'b0);
		row(8'h00, 1'b0);
		row_out(8'h01, 1'b1, ST_FEW, 16'h0000, 16'h0000);
		// unknown integer prefix
		row(CHAR_UNDER, 1'b0);
		row(CH_S, 1'b0);
		row(CH_5, 1'b0);
		row(CHAR_UNDER, 1'b0);
		row(PACKAGE_OP, 1'b0);
		row(8'h3F, 1'b0);
		row(8'h02, 1'b0);
		row_out(8'h0D, 1'b1, ST_BAD_INT, 16'h0000, 16'h0000);
		// table ends right after the name
		row(CHAR_UNDER, 1'b0);
		row(CH_S, 1'b0);
		row(CH_5, 1'b0);
		row_out(CHAR_UNDER, 1'b1, ST_TRUNC, 16'h0000, 16'h0000);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			s = dir_rows[i];
			steady_in = ($urandom_range(0, 1) == 0);
			send_byte(s.b, s.eot, s.typed, s.want);
		end

		t = 0;
		while (bytes_sent < dir_rows.size() + RANDOM_BYTES) begin
			if (t == 10) begin
				// hold the result side off while one-byte tables keep coming
				hold_req = 1'b1;
				steady_in = 1'b1;
				repeat (12) begin
					x = 8'($urandom);
					send_byte(x, 1'b1, 1'b0, none);
				end
			end
			if (t == 25) begin
				// pause the input until every pending result has drained
				@(negedge clk);
				in_valid = 1'b0;
				while (sleep_words_q.size() != 0)
					@(posedge clk);
			end
			build_table();
			steady_in = ($urandom_range(0, 3) == 0);
			foreach (tbl_q[i])
				send_byte(tbl_q[i], i == tbl_q.size() - 1, 1'b0, none);
			t++;
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (sleep_words_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Sent %0d bytes in %0d tables; %0d results checked, %0d mismatches.",
			bytes_sent, tables_sent, results_seen, errors);
		$display("Status mix: ok %0d, not found %0d, no package %0d, few %0d, bad int %0d, trunc %0d.",
			status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_NO_PKG],
			status_seen[ST_FEW], status_seen[ST_BAD_INT], status_seen[ST_TRUNC]);
		if (errors == 0)
			$display("aml_s5_sleep_type_extract verification clean");
		else
			$display("aml_s5_sleep_type_extract verification failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/aml_s5_pkg.sv
sv/aml_s5_sleep_type_extract.sv
dv/tb.sv
